// File: rtl/length_prefix_deframer_assert.svh
// assertion macros for the length prefix deframer
// depends on nothing; taken in by the top level
`ifndef LENGTH_PREFIX_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
`define LPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpd assertion failed");
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpd assertion failed");
`else
`define LPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lpd_pkg.sv
// shared types and constants of the length prefix deframer
// depends on nothing
package lpd_pkg;

    localparam int LPD_MAX_HEADER_BYTES = 8;
    localparam int LPD_FIFO_DEPTH       = 4;
    localparam int LPD_LEN_W            = 64;
    localparam int LPD_CFG_W            = 4;

    localparam logic [LPD_CFG_W-1:0] LPD_HEADER_BYTES_RESET = 4'd4;
    localparam logic                 LPD_BIG_ENDIAN_RESET   = 1'b1;

    typedef enum logic [0:0] {
        LPD_REG_HEADER_BYTES = 1'b0,
        LPD_REG_BIG_ENDIAN   = 1'b1
    } lpd_reg_t;

    typedef enum logic [0:0] {
        LPD_HEADER  = 1'b0,
        LPD_PAYLOAD = 1'b1
    } lpd_state_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       message_end;
        logic       empty_message;
    } lpd_result_t;

endpackage

// File: rtl/length_prefix_deframer.sv
// top level of the length prefix deframer
// depends on lpd_pkg, lpd_front, lpd_fifo and length_prefix_deframer_assert.svh
//
// Splits a byte stream into length-prefixed messages. Each message starts with a
// header of header_bytes bytes (clamped to 1..MAX_HEADER_BYTES), big- or
// little-endian per big_endian; header bytes give no result. The next length
// bytes come out as payload with message_end on the last; a zero length gives
// one result with empty_message and message_end set. One byte is taken per
// cycle while full is low. Results are written into a FIFO_DEPTH-entry queue
// and show on the ports once earlier ones are popped; full is high while that
// queue holds FIFO_DEPTH results, so a consumer that pops every cycle never
// stalls the input. Configuration writes take effect on the next byte.
`include "length_prefix_deframer_assert.svh"

module length_prefix_deframer #(
    parameter int MAX_HEADER_BYTES = lpd_pkg::LPD_MAX_HEADER_BYTES,
    parameter int FIFO_DEPTH       = lpd_pkg::LPD_FIFO_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [0:0]                     cfg_index,
    input  logic [lpd_pkg::LPD_CFG_W-1:0]  cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     stream_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     payload_byte,
    output logic                           message_end,
    output logic                           empty_message
);

    logic                 accept;
    logic                 res_valid;
    lpd_pkg::lpd_result_t res;
    lpd_pkg::lpd_result_t head;

    assign accept = push && !full;

    lpd_front #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .stream_byte (stream_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    lpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    assign payload_byte  = head.payload_byte;
    assign message_end   = head.message_end;
    assign empty_message = head.empty_message;

    `LPD_ASSERT_NOW(a_result_only_on_transfer, clk, rst_n, res_valid, accept)
    `LPD_ASSERT_NOW(a_empty_marker_form, clk, rst_n, !empty && empty_message,
        message_end && (payload_byte == 8'h00))
    `LPD_ASSERT_NEXT(a_result_reaches_port, clk, rst_n, res_valid && empty, !empty)

endmodule

// File: rtl/lpd_front.sv
// front part: configuration registers, header collection and payload counting
// depends on lpd_pkg; feeds result items into lpd_fifo
module lpd_front #(
    parameter int MAX_HEADER_BYTES = lpd_pkg::LPD_MAX_HEADER_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [0:0]                     cfg_index,
    input  logic [lpd_pkg::LPD_CFG_W-1:0]  cfg_data,
    input  logic                           accept,
    input  logic [7:0]                     stream_byte,
    output logic                           res_valid,
    output lpd_pkg::lpd_result_t           res
);

    lpd_pkg::lpd_state_t state_reg, state_next;
    logic [3:0]                     header_count_reg, header_count_next;
    logic [lpd_pkg::LPD_LEN_W-1:0]  length_accum_reg, length_accum_next;
    logic [lpd_pkg::LPD_LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [lpd_pkg::LPD_CFG_W-1:0]  header_bytes_reg;
    logic                           big_endian_reg;

    logic [3:0]                     eff_width;
    logic [3:0]                     count_inc;
    logic [lpd_pkg::LPD_LEN_W-1:0]  accum_le;
    logic [lpd_pkg::LPD_LEN_W-1:0]  accum_new;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg <= lpd_pkg::LPD_HEADER_BYTES_RESET;
            big_endian_reg   <= lpd_pkg::LPD_BIG_ENDIAN_RESET;
        end
        else if (cfg_write)
        begin
            case (lpd_pkg::lpd_reg_t'(cfg_index))
                lpd_pkg::LPD_REG_HEADER_BYTES: header_bytes_reg <= cfg_data;
                lpd_pkg::LPD_REG_BIG_ENDIAN:   big_endian_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lpd_pkg::LPD_HEADER;
            header_count_reg <= '0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            header_count_reg <= header_count_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

    always_comb
    begin
        if (header_bytes_reg == 4'd0)
            eff_width = 4'd1;
        else if (header_bytes_reg > 4'(MAX_HEADER_BYTES))
            eff_width = 4'(MAX_HEADER_BYTES);
        else
            eff_width = header_bytes_reg;
    end

    assign count_inc = header_count_reg + 4'd1;

    // little-endian placement: one byte lane selected by the count
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            accum_le[8*i +: 8] = length_accum_reg[8*i +: 8]
                | ((header_count_reg[2:0] == 3'(i)) ? stream_byte : 8'h00);
        end
    end

    assign accum_new = big_endian_reg
        ? {length_accum_reg[lpd_pkg::LPD_LEN_W-9:0], stream_byte} : accum_le;

    always_comb
    begin
        state_next        = state_reg;
        header_count_next = header_count_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        res_valid         = 1'b0;
        res               = '0;
        case (state_reg)
            lpd_pkg::LPD_PAYLOAD:
            begin
                if (accept)
                begin
                    bytes_left_next   = bytes_left_reg - 64'd1;
                    res_valid         = 1'b1;
                    res.payload_byte  = stream_byte;
                    res.message_end   = (bytes_left_reg == 64'd1);
                    if (bytes_left_reg == 64'd1)
                        state_next = lpd_pkg::LPD_HEADER;
                end
            end
            lpd_pkg::LPD_HEADER:
            begin
                if (accept)
                begin
                    if (count_inc < eff_width)
                    begin
                        header_count_next = count_inc;
                        length_accum_next = accum_new;
                    end
                    else
                    begin
                        header_count_next = '0;
                        length_accum_next = '0;
                        if (accum_new == '0)
                        begin
                            res_valid         = 1'b1;
                            res.message_end   = 1'b1;
                            res.empty_message = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = accum_new;
                            state_next      = lpd_pkg::LPD_PAYLOAD;
                        end
                    end
                end
            end
            default:
            begin
                state_next = lpd_pkg::LPD_HEADER;
            end
        endcase
    end

endmodule

// File: rtl/lpd_fifo.sv
// back part: short result queue that drives the result ports
// depends on lpd_pkg; written by lpd_front
module lpd_fifo #(
    parameter int DEPTH = lpd_pkg::LPD_FIFO_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  lpd_pkg::lpd_result_t  wr_data,
    input  logic                  rd_en,
    output lpd_pkg::lpd_result_t  rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpd_pkg::lpd_result_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
